### rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// types, codes and decode functions of the graphic-rendition decoder
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int CODE_BITS  = 16;
    localparam int COLOR_BITS = 24;
    localparam int OUT_BITS   = 56;

    localparam logic [CODE_BITS-1:0] C_RESET     = 16'd0;
    localparam logic [CODE_BITS-1:0] C_BOLD      = 16'd1;
    localparam logic [CODE_BITS-1:0] C_UNDER     = 16'd4;
    localparam logic [CODE_BITS-1:0] C_INVERSE   = 16'd7;
    localparam logic [CODE_BITS-1:0] C_BOLD_OFF  = 16'd22;
    localparam logic [CODE_BITS-1:0] C_UNDER_OFF = 16'd24;
    localparam logic [CODE_BITS-1:0] C_INV_OFF   = 16'd27;
    localparam logic [CODE_BITS-1:0] C_FG_BASE   = 16'd30;
    localparam logic [CODE_BITS-1:0] C_FG_EXT    = 16'd38;
    localparam logic [CODE_BITS-1:0] C_FG_DEF    = 16'd39;
    localparam logic [CODE_BITS-1:0] C_BG_BASE   = 16'd40;
    localparam logic [CODE_BITS-1:0] C_BG_EXT    = 16'd48;
    localparam logic [CODE_BITS-1:0] C_BG_DEF    = 16'd49;
    localparam logic [CODE_BITS-1:0] C_FG_BRIGHT = 16'd90;
    localparam logic [CODE_BITS-1:0] C_BG_BRIGHT = 16'd100;
    localparam logic [CODE_BITS-1:0] C_SEL_IDX   = 16'd5;
    localparam logic [CODE_BITS-1:0] C_SEL_RGB   = 16'd2;
    localparam logic [CODE_BITS-1:0] C_MAX8      = 16'd255;
    localparam logic [CODE_BITS-1:0] C_SPAN      = 16'd7;

    typedef enum logic [1:0] {
        KIND_DEF = 2'd0,
        KIND_IDX = 2'd1,
        KIND_RGB = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEL  = 3'd1,
        PH_IDX  = 3'd2,
        PH_R    = 3'd3,
        PH_G    = 3'd4,
        PH_B    = 3'd5
    } t_phase;

    typedef struct packed {
        logic                  bold;
        logic                  underline;
        logic                  inverse;
        t_kind                 fg_kind;
        logic [COLOR_BITS-1:0] fg_value;
        t_kind                 bg_kind;
        logic [COLOR_BITS-1:0] bg_value;
    } t_attr;

    function automatic logic [7:0] clamp8(input logic [CODE_BITS-1:0] v);
        logic [7:0] r;
        r = (v > C_MAX8) ? 8'hff : v[7:0];
        return r;
    endfunction

    function automatic logic in_span(input logic [CODE_BITS-1:0] v,
                                     input logic [CODE_BITS-1:0] base);
        logic r;
        r = (v >= base) && (v <= base + C_SPAN);
        return r;
    endfunction

    function automatic t_attr apply_plain(input t_attr a, input logic [CODE_BITS-1:0] v);
        t_attr r;
        logic [CODE_BITS-1:0] d;
        r = a;
        d = '0;
        if (v == C_RESET) begin
            r.bold      = 1'b0;
            r.underline = 1'b0;
            r.inverse   = 1'b0;
            r.fg_kind   = KIND_DEF;
            r.fg_value  = '0;
            r.bg_kind   = KIND_DEF;
            r.bg_value  = '0;
        end else if (v == C_BOLD) begin
            r.bold = 1'b1;
        end else if (v == C_UNDER) begin
            r.underline = 1'b1;
        end else if (v == C_INVERSE) begin
            r.inverse = 1'b1;
        end else if (v == C_BOLD_OFF) begin
            r.bold = 1'b0;
        end else if (v == C_UNDER_OFF) begin
            r.underline = 1'b0;
        end else if (v == C_INV_OFF) begin
            r.inverse = 1'b0;
        end else if (v == C_FG_DEF) begin
            r.fg_kind  = KIND_DEF;
            r.fg_value = '0;
        end else if (v == C_BG_DEF) begin
            r.bg_kind  = KIND_DEF;
            r.bg_value = '0;
        end else if (in_span(v, C_FG_BASE)) begin
            d          = v - C_FG_BASE;
            r.fg_kind  = KIND_IDX;
            r.fg_value = {21'd0, d[2:0]};
        end else if (in_span(v, C_BG_BASE)) begin
            d          = v - C_BG_BASE;
            r.bg_kind  = KIND_IDX;
            r.bg_value = {21'd0, d[2:0]};
        end else if (in_span(v, C_FG_BRIGHT)) begin
            d          = v - C_FG_BRIGHT;
            r.fg_kind  = KIND_IDX;
            r.fg_value = {20'd0, 1'b1, d[2:0]};
        end else if (in_span(v, C_BG_BRIGHT)) begin
            d          = v - C_BG_BRIGHT;
            r.bg_kind  = KIND_IDX;
            r.bg_value = {20'd0, 1'b1, d[2:0]};
        end
        return r;
    endfunction

endpackage

### rtl/sgr_attribute_decoder_top.sv
// ----------------------------------------------------------------------------
// sgr_attribute_decoder_top
// graphic-rendition parameter decoder keeping text attributes and colors
// ----------------------------------------------------------------------------
// Takes one parameter per item, the last parameter of a sequence marked by
// tlast, and gives the full attribute set once per sequence, loaded into the
// output register when the last item leaves the input register. One item is
// taken every cycle unless a last item meets a stalled output: each item
// passes an input register and one stage of compare logic that updates the
// attribute and pending-form registers. A finished attribute set waits in
// the output register while later items still pass through.
// ----------------------------------------------------------------------------
module sgr_attribute_decoder_top #(
    parameter int PARAM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // param_value[15:0]
    input  logic        i_s_axis_tlast,  // param_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // bold_on[0], underline_on[1], inverse_on[2], fg_kind[4:3], fg_value[28:5],
    // bg_kind[30:29], bg_value[54:31], zero[55]
    output logic [55:0] o_m_axis_tdata
);

    localparam int VAL_BITS = (PARAM_BITS < 16) ? PARAM_BITS : 16;
    localparam logic [15:0] VAL_MASK = 16'((17'd1 << VAL_BITS) - 17'd1);

    logic                r_in_valid;
    logic [15:0]         r_in_value;
    logic                r_in_last;
    sgr_pkg::t_phase     r_phase, n_phase;
    logic                r_is_fore, n_is_fore;
    logic [VAL_BITS-1:0] r_pend_r, n_pend_r;
    logic [VAL_BITS-1:0] r_pend_g, n_pend_g;
    sgr_pkg::t_attr      r_attr, n_attr;
    logic                r_out_valid;
    sgr_pkg::t_attr      r_out_attr;

    sgr_pkg::t_phase     w_feed_phase;
    logic                w_plain;
    logic                w_advance;
    logic                w_ext;

    assign w_advance = r_in_valid && !(r_in_last && r_out_valid && !i_m_axis_tready);
    assign w_ext     = (r_in_value == sgr_pkg::C_FG_EXT) || (r_in_value == sgr_pkg::C_BG_EXT);

    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_attr.bg_value, r_out_attr.bg_kind,
                              r_out_attr.fg_value, r_out_attr.fg_kind,
                              r_out_attr.inverse, r_out_attr.underline,
                              r_out_attr.bold};

    // phase and pending form
    always_comb begin
        w_feed_phase = r_phase;
        w_plain      = 1'b0;
        n_is_fore    = r_is_fore;
        n_pend_r     = r_pend_r;
        n_pend_g     = r_pend_g;
        unique case (r_phase)
            sgr_pkg::PH_SEL: begin
                if (r_in_value == sgr_pkg::C_SEL_IDX) begin
                    w_feed_phase = sgr_pkg::PH_IDX;
                end else if (r_in_value == sgr_pkg::C_SEL_RGB) begin
                    w_feed_phase = sgr_pkg::PH_R;
                end else if (w_ext) begin
                    w_feed_phase = sgr_pkg::PH_SEL;
                    n_is_fore    = (r_in_value == sgr_pkg::C_FG_EXT);
                end else begin
                    w_feed_phase = sgr_pkg::PH_IDLE;
                    w_plain      = 1'b1;
                end
            end
            sgr_pkg::PH_IDX: begin
                w_feed_phase = sgr_pkg::PH_IDLE;
            end
            sgr_pkg::PH_R: begin
                n_pend_r     = r_in_value[VAL_BITS-1:0];
                w_feed_phase = sgr_pkg::PH_G;
            end
            sgr_pkg::PH_G: begin
                n_pend_g     = r_in_value[VAL_BITS-1:0];
                w_feed_phase = sgr_pkg::PH_B;
            end
            sgr_pkg::PH_B: begin
                w_feed_phase = sgr_pkg::PH_IDLE;
            end
            default: begin
                if (w_ext) begin
                    w_feed_phase = sgr_pkg::PH_SEL;
                    n_is_fore    = (r_in_value == sgr_pkg::C_FG_EXT);
                end else begin
                    w_feed_phase = sgr_pkg::PH_IDLE;
                    w_plain      = 1'b1;
                end
            end
        endcase
        if (!w_advance) begin
            n_phase   = r_phase;
            n_is_fore = r_is_fore;
            n_pend_r  = r_pend_r;
            n_pend_g  = r_pend_g;
        end else if (r_in_last) begin
            n_phase = sgr_pkg::PH_IDLE;
        end else begin
            n_phase = w_feed_phase;
        end
    end

    // attribute update
    always_comb begin
        n_attr = r_attr;
        if (w_advance) begin
            if (w_plain) begin
                n_attr = sgr_pkg::apply_plain(n_attr, r_in_value);
            end else if (r_phase == sgr_pkg::PH_IDX) begin
                if (r_is_fore) begin
                    n_attr.fg_kind  = sgr_pkg::KIND_IDX;
                    n_attr.fg_value = {16'd0, sgr_pkg::clamp8(r_in_value)};
                end else begin
                    n_attr.bg_kind  = sgr_pkg::KIND_IDX;
                    n_attr.bg_value = {16'd0, sgr_pkg::clamp8(r_in_value)};
                end
            end else if (r_phase == sgr_pkg::PH_B) begin
                if (r_is_fore) begin
                    n_attr.fg_kind  = sgr_pkg::KIND_RGB;
                    n_attr.fg_value = {sgr_pkg::clamp8(16'(r_pend_r)),
                                       sgr_pkg::clamp8(16'(r_pend_g)),
                                       sgr_pkg::clamp8(r_in_value)};
                end else begin
                    n_attr.bg_kind  = sgr_pkg::KIND_RGB;
                    n_attr.bg_value = {sgr_pkg::clamp8(16'(r_pend_r)),
                                       sgr_pkg::clamp8(16'(r_pend_g)),
                                       sgr_pkg::clamp8(r_in_value)};
                end
            end
            if (r_in_last && (w_feed_phase == sgr_pkg::PH_G ||
                              w_feed_phase == sgr_pkg::PH_B)) begin
                n_attr = sgr_pkg::apply_plain(n_attr, 16'(n_pend_r));
            end
            if (r_in_last && (w_feed_phase == sgr_pkg::PH_B)) begin
                n_attr = sgr_pkg::apply_plain(n_attr, 16'(n_pend_g));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= sgr_pkg::PH_IDLE;
            r_is_fore   <= 1'b0;
            r_attr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            r_phase   <= n_phase;
            r_is_fore <= n_is_fore;
            r_attr    <= n_attr;
            if (w_advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_value <= i_s_axis_tdata & VAL_MASK;
            r_in_last  <= i_s_axis_tlast;
        end
        r_pend_r <= n_pend_r;
        r_pend_g <= n_pend_g;
        if (w_advance && r_in_last) begin
            r_out_attr <= n_attr;
        end
    end

endmodule

### rtl/sgr_checker.sv
// ----------------------------------------------------------------------------
// sgr_checker
// port-level checks of the graphic-rendition decoder, bound to the top level
// ----------------------------------------------------------------------------
module sgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output stall");

    // a new result follows a last item
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2))
        else $error("result without last item");

    // color kinds and values agree
    a_color_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[4:3] != 2'd3) && (o_m_axis_tdata[30:29] != 2'd3) &&
            (o_m_axis_tdata[4:3] != 2'd0 || o_m_axis_tdata[28:5] == 24'd0) &&
            (o_m_axis_tdata[30:29] != 2'd0 || o_m_axis_tdata[54:31] == 24'd0) &&
            (o_m_axis_tdata[4:3] != 2'd1 || o_m_axis_tdata[28:13] == 16'd0) &&
            (o_m_axis_tdata[30:29] != 2'd1 || o_m_axis_tdata[54:39] == 16'd0) &&
            !o_m_axis_tdata[55])
        else $error("inconsistent color fields");

endmodule

bind sgr_attribute_decoder_top sgr_checker u_sgr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
